// ===== hdl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int KIND_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = 16;
    localparam int READ_ROW_W  = 5;
    localparam int READ_COL_W  = 7;
    localparam int CUR_ROW_W   = 5;
    localparam int CUR_COL_W   = 7;

    localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0F00;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] END_CODE     = 8'd0;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_COPY,
        S_FLUSH,
        S_BLANK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sweep_clr;     // restart the sweep counter at cell zero
        logic fill;          // write the blank cell at the sweep counter
        logic copy_step;     // read one row below the sweep counter
        logic put;           // take a put-character request
        logic home;          // move the cursor to the top left
        logic read_issue;    // start a cell read
        logic load_result;   // load the result register
        logic cell_from_ram; // result cell comes from the read data
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic put_scroll;    // the put request moves past the bottom row
        logic copy_last;     // last cell of the scroll copy
        logic fill_last;     // last cell of the screen
    } t_dp_status;

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcw_datapath.sv =====
// Datapath of the text console writer: cursor, sweep counter, screen memory,
// blank-cell register and result register. Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  logic [CELL_W-1:0]     i_cfg_blank_cell,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [READ_ROW_W-1:0] i_read_row,
    input  logic [READ_COL_W-1:0] i_read_col,
    output logic [CUR_ROW_W-1:0]  o_cursor_row,
    output logic [CUR_COL_W-1:0]  o_cursor_col,
    output logic [CELL_W-1:0]     o_cell_value
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = $clog2(ROWS);

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_pend_valid;
    logic [ADDR_W-1:0] r_pend_addr;
    logic [CELL_W-1:0] r_blank;
    logic              r_read_ok;
    logic [CUR_ROW_W-1:0] r_out_row;
    logic [CUR_COL_W-1:0] r_out_col;
    logic [CELL_W-1:0]    r_out_cell;

    logic              is_newline;
    logic              is_printable;
    logic              last_col;
    logic              last_row;
    logic              line_end;
    logic              read_in_range;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic [31:0]       row_wide;
    logic [31:0]       col_wide;

    assign is_newline   = (i_char_code == NEWLINE_CODE);
    assign is_printable = (i_char_code != END_CODE) && !is_newline;
    assign last_col     = (32'(r_col) == COLUMNS - 1);
    assign last_row     = (32'(r_row) == ROWS - 1);
    assign line_end     = is_newline || (is_printable && last_col);

    assign cur_addr  = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
    assign read_addr = ADDR_W'(32'(i_read_row) * COLUMNS + 32'(i_read_col));
    assign read_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

    assign o_status.put_scroll = line_end && last_row;
    assign o_status.copy_last  = (32'(r_sweep) == COPY_N - 1);
    assign o_status.fill_last  = (32'(r_sweep) == CELLS - 1);

    // Cursor update for the current request.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.home) begin
            n_row = '0;
            n_col = '0;
        end else if (i_cmd.put) begin
            if (line_end) begin
                n_col = '0;
                if (!last_row) begin
                    n_row = r_row + ROW_W'(1);
                end
            end else if (is_printable) begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // The pending copy write has the port to itself; the controller never
    // fills or puts while it is outstanding.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sweep;
        ram_wdata = r_blank;
        if (r_pend_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_pend_addr;
            ram_wdata = ram_rdata;
        end else if (i_cmd.fill) begin
            ram_we    = 1'b1;
        end else if (i_cmd.put && is_printable) begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
            ram_wdata = {i_color, i_char_code};
        end
    end

    assign ram_raddr = i_cmd.copy_step ? ADDR_W'(32'(r_sweep) + COLUMNS) : read_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_sweep      <= '0;
            r_pend_valid <= 1'b0;
            r_blank      <= BLANK_RESET;
            r_read_ok    <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_pend_valid <= i_cmd.copy_step;
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.fill || i_cmd.copy_step) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                r_blank <= i_cfg_blank_cell;
            end
            if (i_cmd.read_issue) begin
                r_read_ok <= read_in_range;
            end
        end
    end

    assign row_wide = 32'(n_row);
    assign col_wide = 32'(n_col);

    always_ff @(posedge i_clk) begin
        r_pend_addr <= r_sweep;
        if (i_cmd.load_result) begin
            r_out_row  <= row_wide[CUR_ROW_W-1:0];
            r_out_col  <= col_wide[CUR_COL_W-1:0];
            r_out_cell <= (i_cmd.cell_from_ram && r_read_ok) ? ram_rdata : '0;
        end
    end

    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_cell_value = r_out_cell;

endmodule

// ===== hdl/tcw_ctrl.sv =====
// Controller of the text console writer: request handshakes, sweep sequencing
// and result valid. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_cfg_ready,
    output t_dp_cmd           o_cmd,
    input  t_dp_status        i_status
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_take;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // The blank cell may only change while no sweep is running, so the
    // clearing pass after reset always writes the reset value.
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_kind)
                        KIND_PUT: begin
                            o_cmd.put = 1'b1;
                            if (i_status.put_scroll) begin
                                o_cmd.sweep_clr = 1'b1;
                                n_state         = S_COPY;
                            end else begin
                                o_cmd.load_result = 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            o_cmd.home      = 1'b1;
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = S_CLEAR;
                        end
                        KIND_READ: begin
                            o_cmd.read_issue = 1'b1;
                            n_state          = S_READ;
                        end
                        default: begin
                            o_cmd.load_result = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.load_result   = 1'b1;
                o_cmd.cell_from_ram = 1'b1;
                n_state             = S_IDLE;
            end
            S_CLEAR, S_BLANK: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // The last copied cell is written here; the sweep counter
                // already points at the first cell of the bottom row.
                n_state = S_BLANK;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/text_console_writer.sv =====
// Text console writer top level: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and tcw_ram.
`timescale 1ns / 1ps

// The console keeps a ROWS x COLUMNS screen of 16-bit cells (color byte over
// character byte) in one block RAM with a registered read, and a cursor.
// After reset a clearing pass writes the blank cell to every cell with the
// request channel held off; configuration writes are taken only while no
// clearing or scrolling pass runs. A put of an ordinary character, a newline
// that stays on screen, a character zero and an unused kind are each handled
// in the idle state, so such requests stream at one per cycle while results
// are taken. A cell read passes through the read state because the RAM read
// is registered. A clear walks the screen with the single RAM write port.
// A put that moves past the bottom row scrolls: each cell of rows 1 and up is
// read and written one row higher, one per cycle, then the bottom row is
// blanked. Each request gives exactly one result with the cursor after it;
// the result register frees the request side as soon as the previous result
// is taken.

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [READ_ROW_W-1:0] i_read_row,
    input  logic [READ_COL_W-1:0] i_read_col,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CUR_ROW_W-1:0]  o_cursor_row,
    output logic [CUR_COL_W-1:0]  o_cursor_col,
    output logic [CELL_W-1:0]     o_cell_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CELL_W-1:0]     i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_take;

    assign cfg_take = i_cfg_valid && o_cfg_ready;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_cfg_we         (cfg_take),
        .i_cfg_blank_cell (i_cfg_data),
        .i_char_code      (i_char_code),
        .i_color          (i_color),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_col     (o_cursor_col),
        .o_cell_value     (o_cell_value)
    );

endmodule
